### src/windowed_trade_vwap_macros.svh
// assertion macros shared by the vwap block
// no dependencies
`ifndef WINDOWED_TRADE_VWAP_MACROS_SVH
`define WINDOWED_TRADE_VWAP_MACROS_SVH

// property checked every clock, off during reset
`define WTV_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked every clock, off during reset
`define WTV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### src/wtv_pkg.sv
// shared constants and types for the windowed vwap block
// no dependencies
package wtv_pkg;
   localparam int unsigned WindowDepthDefault = 256;
   localparam int unsigned SymbolBitsDefault  = 64;
   localparam int unsigned PriceBitsDefault   = 32;
   localparam int unsigned SymbolFieldBits    = 64;
   localparam int unsigned PriceFieldBits     = 32;
   localparam int unsigned QtyBits            = 24;
   localparam int unsigned CountBits          = 9;
   localparam int unsigned ResultBits         = 32;
   localparam int unsigned WinCfgBits         = 9;
   localparam logic [WinCfgBits-1:0] WinResetValue = 9'd256;

   typedef enum logic {
      CMD_RECORD = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   // result kind carried on the result side
   typedef enum logic {
      STATUS_RECORDED = 1'b0,
      STATUS_STATS    = 1'b1
   } status_type;

   // divider handshake between the top level and the divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

### src/wtv_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module wtv_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/wtv_div.sv
// restoring divider, one quotient bit per cycle, result saturated to out width
// depends on wtv_pkg
module wtv_div #(
   parameter int unsigned NUM_BITS = 80,
   parameter int unsigned DEN_BITS = 32,
   parameter int unsigned Q_BITS   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output wtv_pkg::div_ctl_type ctl,
   output logic [Q_BITS-1:0]   quot
);
   import wtv_pkg::*;
   localparam int unsigned CntBits = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DEN_BITS:0]   shifted;
   logic                take;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DEN_BITS-1:0], num_ff[NUM_BITS-1]};
      take    = shifted >= {1'b0, den_ff};
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CntBits'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = take ? shifted - {1'b0, den_ff} : shifted;
         q_in   = {q_ff[NUM_BITS-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   // zero divisor gives zero, wide quotient saturates
   always_comb begin
      if (den_ff == '0) begin
         quot = '0;
      end else if (NUM_BITS > Q_BITS && (q_ff >> Q_BITS) != '0) begin
         quot = '1;
      end else begin
         quot = Q_BITS'(q_ff);
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
endmodule

### src/windowed_trade_vwap.sv
// windowed trade vwap: a record's result beat is valid the cycle after its accept
// a query walks the stored trades, then runs two serial divisions on the shared
// divider before its result beat is valid; one beat in flight, next accept the
// cycle after the result beat
// synchronous reset clears count and oldest slot and sets window size to 256; stores
// hold garbage until written and are never read before
module windowed_trade_vwap #(
   parameter int unsigned WINDOW_DEPTH = wtv_pkg::WindowDepthDefault,
   parameter int unsigned SYMBOL_BITS  = wtv_pkg::SymbolBitsDefault,
   parameter int unsigned PRICE_BITS   = wtv_pkg::PriceBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: symbol[63:0], price[95:64], quantity[119:96]
   input  logic [119:0] req_tdata,
   // tuser: cmd[0]
   input  logic         req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: match_count[8:0], vol_sum[40:9], avg_price[72:41],
   // vwap[104:73], pad to 112
   output logic [111:0] rsp_tdata,
   // tuser: status[0]
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data
);
   import wtv_pkg::*;
   `include "windowed_trade_vwap_macros.svh"

   localparam int unsigned AddrBits  = $clog2(WINDOW_DEPTH);
   localparam int unsigned CntW      = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned PsumBits  = PRICE_BITS + CntW;
   localparam int unsigned ProdBits  = PRICE_BITS + QtyBits;
   localparam int unsigned WsumBits  = ProdBits + CntW;
   localparam int unsigned VolBits   = QtyBits + CntW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WALK, ST_DIV_AVG, ST_DIV_VWAP, ST_SEND
   } state_type;

   state_type state_ff;
   logic [WinCfgBits-1:0] win_ff;
   logic [AddrBits-1:0]   oldest_ff;
   logic [CntW-1:0]       count_ff;
   logic [SYMBOL_BITS-1:0] qsym_ff;
   logic [CntW-1:0]       issue_ff;    // walk read address offset
   logic                  rd_vld_ff;   // ram read data valid
   logic [CntW-1:0]       mcnt_ff;
   logic [VolBits-1:0]    vol_ff;
   logic [PsumBits-1:0]   psum_ff;
   logic [WsumBits-1:0]   wsum_ff;
   logic                  prod_vld_ff, prod_hit_ff;
   logic [ProdBits-1:0]   prod_ff;
   logic [QtyBits-1:0]    pqty_ff;
   logic [PRICE_BITS-1:0] pprice_ff;
   logic [ResultBits-1:0] avg_ff;
   logic [111:0]          out_ff;
   status_type            out_status_ff;
   logic                  out_vld_ff;
   logic                  div_go_ff;

   // input unpack
   cmd_type               in_cmd;
   logic [SYMBOL_BITS-1:0] in_sym;
   logic [PRICE_BITS-1:0] in_price;
   logic [QtyBits-1:0]    in_qty;
   assign in_cmd   = cmd_type'(req_tuser);
   assign in_sym   = SYMBOL_BITS'(req_tdata[0 +: SymbolFieldBits]);
   assign in_price = PRICE_BITS'(req_tdata[SymbolFieldBits +: PriceFieldBits]);
   assign in_qty   = req_tdata[SymbolFieldBits + PriceFieldBits +: QtyBits];

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !out_vld_ff;
   assign accept     = req_tvalid && req_tready;

   // effective window: zero acts as one, clipped to depth
   logic [CntW-1:0] win_eff;
   always_comb begin
      if (win_ff == '0) begin
         win_eff = CntW'(1);
      end else if (32'(win_ff) > WINDOW_DEPTH) begin
         win_eff = CntW'(WINDOW_DEPTH);
      end else begin
         win_eff = CntW'(win_ff);
      end
   end

   function automatic logic [AddrBits-1:0] slot_add(input logic [AddrBits-1:0] base,
                                                    input logic [CntW-1:0] off);
      logic [CntW:0] s;
      s = (CntW+1)'(base) + (CntW+1)'(off);
      if (s >= (CntW+1)'(WINDOW_DEPTH)) begin
         s = s - (CntW+1)'(WINDOW_DEPTH);
      end
      return AddrBits'(s);
   endfunction

   // record path
   logic                evict;
   logic [AddrBits-1:0] oldest_next;
   logic [CntW-1:0]     count_after_evict;
   logic [AddrBits-1:0] wr_addr;
   logic                wr_en;
   assign evict             = (count_ff >= win_eff) && (count_ff != '0);
   assign oldest_next       = evict ? slot_add(oldest_ff, CntW'(1)) : oldest_ff;
   assign count_after_evict = evict ? count_ff - 1'b1 : count_ff;
   assign wr_addr           = slot_add(oldest_next, count_after_evict);
   assign wr_en             = accept && (in_cmd == CMD_RECORD);

   // memories
   logic [AddrBits-1:0]    rd_addr;
   logic [SYMBOL_BITS-1:0] rd_sym;
   logic [PRICE_BITS-1:0]  rd_price;
   logic [QtyBits-1:0]     rd_qty;
   assign rd_addr = slot_add(oldest_ff, issue_ff);

   wtv_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(WINDOW_DEPTH)) u_sym_ram (
      .clock, .wr_en, .wr_addr, .wr_data(in_sym), .rd_addr, .rd_data(rd_sym));
   wtv_ram #(.WIDTH(PRICE_BITS), .DEPTH(WINDOW_DEPTH)) u_price_ram (
      .clock, .wr_en, .wr_addr, .wr_data(in_price), .rd_addr, .rd_data(rd_price));
   wtv_ram #(.WIDTH(QtyBits), .DEPTH(WINDOW_DEPTH)) u_qty_ram (
      .clock, .wr_en, .wr_addr, .wr_data(in_qty), .rd_addr, .rd_data(rd_qty));

   // one shared divider: mean price first, then vwap
   logic [WsumBits-1:0] div_num;
   logic [VolBits-1:0]  div_den;
   div_ctl_type         div_ctl;
   logic [ResultBits-1:0] div_q;
   always_comb begin
      if (state_ff == ST_DIV_AVG) begin
         div_num = WsumBits'(psum_ff);
         div_den = VolBits'(mcnt_ff);
      end else begin
         div_num = wsum_ff;
         div_den = vol_ff;
      end
   end

   wtv_div #(.NUM_BITS(WsumBits), .DEN_BITS(VolBits), .Q_BITS(ResultBits)) u_div (
      .clock, .reset, .start(div_go_ff), .numer(div_num), .denom(div_den),
      .ctl(div_ctl), .quot(div_q));

   logic walk_last;
   assign walk_last = !rd_vld_ff && !prod_vld_ff && (issue_ff >= count_ff);

   function automatic logic [ResultBits-1:0] sat32(input logic [VolBits-1:0] v);
      if (VolBits > ResultBits && (v >> ResultBits) != '0) begin
         return '1;
      end
      return ResultBits'(v);
   endfunction

   // match count clamps at the field width for deep windows
   function automatic logic [CountBits-1:0] sat_count(input logic [CntW-1:0] v);
      if (CntW > CountBits && (v >> CountBits) != '0) begin
         return '1;
      end
      return CountBits'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         win_ff      <= WinResetValue;
         oldest_ff   <= '0;
         count_ff    <= '0;
         out_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         div_go_ff   <= 1'b0;
         issue_ff    <= '0;
      end else begin
         div_go_ff <= 1'b0;
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         if (out_vld_ff && rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && in_cmd == CMD_RECORD) begin
                  oldest_ff     <= oldest_next;
                  count_ff      <= count_after_evict + 1'b1;
                  out_ff        <= '0;
                  out_status_ff <= STATUS_RECORDED;
                  out_vld_ff    <= 1'b1;
               end else if (accept) begin
                  qsym_ff  <= in_sym;
                  issue_ff <= '0;
                  mcnt_ff  <= '0;
                  vol_ff   <= '0;
                  psum_ff  <= '0;
                  wsum_ff  <= '0;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               // read, multiply, accumulate pipeline
               rd_vld_ff <= issue_ff < count_ff;
               if (issue_ff < count_ff) begin
                  issue_ff <= issue_ff + 1'b1;
               end
               prod_vld_ff <= rd_vld_ff;
               prod_hit_ff <= rd_sym == qsym_ff;
               prod_ff     <= ProdBits'(rd_price) * ProdBits'(rd_qty);
               pqty_ff     <= rd_qty;
               pprice_ff   <= rd_price;
               if (prod_vld_ff && prod_hit_ff) begin
                  mcnt_ff <= mcnt_ff + 1'b1;
                  vol_ff  <= vol_ff + VolBits'(pqty_ff);
                  psum_ff <= psum_ff + PsumBits'(pprice_ff);
                  wsum_ff <= wsum_ff + WsumBits'(prod_ff);
               end
               if (walk_last) begin
                  div_go_ff <= 1'b1;
                  state_ff  <= ST_DIV_AVG;
               end
            end
            ST_DIV_AVG: begin
               if (div_ctl.done) begin
                  avg_ff    <= div_q;
                  div_go_ff <= 1'b1;
                  state_ff  <= ST_DIV_VWAP;
               end
            end
            ST_DIV_VWAP: begin
               if (div_ctl.done) begin
                  out_ff <= {7'd0, div_q, avg_ff, sat32(vol_ff), sat_count(mcnt_ff)};
                  out_status_ff <= STATUS_STATS;
                  state_ff <= ST_SEND;
               end
            end
            ST_SEND: begin
               out_vld_ff <= 1'b1;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tvalid = out_vld_ff;

   `WTV_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(WINDOW_DEPTH), "stored count above depth")
   `WTV_ASSERT_IMPLY(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready, "ready while busy")
   `WTV_ASSERT_IMPLY(a_match_bound, clock, reset, state_ff == ST_WALK, mcnt_ff <= count_ff, "matches exceed stored")
   `WTV_ASSERT_IMPLY(a_record_grows, clock, reset, wr_en && count_ff < win_eff, ##1 count_ff == $past(count_ff) + 1'b1, "record did not grow count")
endmodule

### tb/sv/windowed_trade_vwap_tb.sv
// self-checking testbench for windowed_trade_vwap: trades and symbol queries
// are driven as beats, results predicted by a local window model and compared
// depends on wtv_pkg and the windowed_trade_vwap rtl
module windowed_trade_vwap_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wtv_pkg::*;

   typedef struct packed {
      logic [23:0] qty;
      logic [31:0] price;
      logic [63:0] symbol;
      cmd_type     cmd;
   } trade_beat_type;

   typedef struct {
      logic        status;
      logic [8:0]  match_count;
      logic [31:0] vol_sum;
      logic [31:0] avg_price;
      logic [31:0] vwap;
   } vwap_result_type;

   // queue entries: a beat, or a config write / drain marker
   typedef struct {
      bit             is_cfg;
      bit             is_drain;
      logic [8:0]     cfg_value;
      trade_beat_type beat;
   } pending_op_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [119:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_wr_en = 1'b0;
   logic [8:0]   csr_wr_data = '0;

   windowed_trade_vwap dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // window model state
   logic [63:0]  win_symbol[256];
   logic [31:0]  win_price[256];
   logic [23:0]  win_qty[256];
   int unsigned  win_oldest;
   int unsigned  win_count;
   logic [8:0]   win_limit;

   pending_op_type  pending_ops[$];
   vwap_result_type expected_results[$];
   int unsigned  mismatch_count;
   longint unsigned cycle_count;
   bit           idle_free;      // no-idle stretch
   bit           hold_rx;        // long receiver hold-off requested
   int unsigned  hold_cycles;
   bit           stim_done;
   logic [63:0]  sym_pool[6];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // 128 by 64 divide, low 64 quotient bits
   function automatic logic [63:0] wide_quotient(input logic [127:0] num,
                                                 input logic [63:0] den);
      logic [127:0] q;
      q = num / {64'd0, den};
      return q[63:0];
   endfunction

   function automatic logic [31:0] clamp32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic vwap_result_type apply_trade_beat(input trade_beat_type b);
      vwap_result_type r;
      int unsigned  lim, s;
      logic [63:0]  n, vol, psum, avg, vw;
      logic [127:0] pq;
      r = '{STATUS_RECORDED, 9'd0, 32'd0, 32'd0, 32'd0};
      if (b.cmd == CMD_RECORD) begin
         lim = 32'(win_limit);
         if (lim == 0) lim = 1;
         if (lim > 256) lim = 256;
         if (win_count >= lim && win_count > 0) begin
            win_oldest = (win_oldest + 1) % 256;
            win_count--;
         end
         s = (win_oldest + win_count) % 256;
         win_symbol[s] = b.symbol;
         win_price[s] = b.price;
         win_qty[s] = b.qty;
         win_count++;
         return r;
      end
      n = 0; vol = 0; psum = 0; pq = 0; avg = 0; vw = 0;
      for (int i = 0; i < win_count; i++) begin
         s = (win_oldest + i) % 256;
         if (win_symbol[s] == b.symbol) begin
            n++;
            vol += 64'(win_qty[s]);
            psum += 64'(win_price[s]);
            pq += 128'(win_price[s]) * 128'(win_qty[s]);
         end
      end
      if (n > 0) avg = psum / n;
      if (vol > 0) vw = wide_quotient(pq, vol);
      r.status = STATUS_STATS;
      r.match_count = (n > 256) ? 9'd256 : n[8:0];
      r.vol_sum = clamp32(vol);
      r.avg_price = clamp32(avg);
      r.vwap = clamp32(vw);
      return r;
   endfunction

   function automatic trade_beat_type make_beat(input cmd_type c, input logic [63:0] sym,
                                                input logic [31:0] p, input logic [23:0] q);
      trade_beat_type b;
      b.cmd = c; b.symbol = sym; b.price = p; b.qty = q;
      return b;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_beat(input trade_beat_type b);
      pending_op_type op;
      op.is_cfg = 0; op.is_drain = 0; op.cfg_value = '0; op.beat = b;
      pending_ops.push_back(op);
   endtask

   task automatic push_cfg(input logic [8:0] v);
      pending_op_type op;
      op = '{1'b1, 1'b0, v, '0};
      pending_ops.push_back(op);
   endtask

   task automatic push_drain();
      pending_op_type op;
      op = '{1'b0, 1'b1, 9'd0, '0};
      pending_ops.push_back(op);
   endtask

   // mostly trades on a small symbol pool, with queries of those symbols
   task automatic push_random(input int n);
      logic [63:0] sym;
      for (int i = 0; i < n; i++) begin
         sym = ($urandom_range(0, 9) == 0) ? rand64() : sym_pool[$urandom_range(0, 5)];
         if ($urandom_range(0, 3) == 0)
            push_beat(make_beat(CMD_QUERY, sym, $urandom, 24'($urandom)));
         else
            push_beat(make_beat(CMD_RECORD, sym,
                                ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 2000000),
                                ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                            : 24'($urandom_range(0, 1000))));
      end
   endtask

   // driver: beats, config writes and drain pauses, all from the falling edge
   bit             drv_busy;
   bit             cfg_write;
   pending_op_type drv_op;
   always @(negedge clock) begin
      if (!reset) begin
         cfg_write = 1'b0;
         if (!drv_busy && pending_ops.size() > 0) begin
            drv_op = pending_ops[0];
            if (drv_op.is_drain || drv_op.is_cfg) begin
               // config writes and drains wait for an idle block
               if (expected_results.size() == 0 && !req_tvalid) begin
                  if (drv_op.is_cfg) begin
                     cfg_write = 1'b1;
                     csr_wr_data <= drv_op.cfg_value;
                     win_limit = drv_op.cfg_value;
                  end
                  void'(pending_ops.pop_front());
               end
            end else if (idle_free || $urandom_range(0, 99) >= 20) begin
               req_tdata <= {drv_op.beat.qty, drv_op.beat.price, drv_op.beat.symbol};
               req_tuser <= drv_op.beat.cmd;
               req_tvalid <= 1'b1;
               drv_busy = 1'b1;
               void'(pending_ops.pop_front());
            end
         end
         csr_wr_en <= cfg_write;
         rsp_tready <= hold_rx ? 1'b0 : (idle_free || $urandom_range(0, 99) >= 20);
      end
   end

   // accept on rising edge; predict at acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(apply_trade_beat(drv_op.beat));
         drv_busy = 1'b0;
         req_tvalid <= 1'b0;
      end
   end

   // monitor
   vwap_result_type got, want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.match_count = rsp_tdata[8:0];
         got.vol_sum = rsp_tdata[40:9];
         got.avg_price = rsp_tdata[72:41];
         got.vwap = rsp_tdata[104:73];
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.match_count !== want.match_count)
               report_mismatch("match_count", 64'(got.match_count), 64'(want.match_count));
            if (got.vol_sum !== want.vol_sum)
               report_mismatch("volume sum", 64'(got.vol_sum), 64'(want.vol_sum));
            if (got.avg_price !== want.avg_price)
               report_mismatch("avg_price", 64'(got.avg_price), 64'(want.avg_price));
            if (got.vwap !== want.vwap)
               report_mismatch("vwap", 64'(got.vwap), 64'(want.vwap));
         end
      end
   end

   // receiver hold-off counted here so the input side backs up
   always @(posedge clock) begin
      if (hold_rx) begin
         hold_cycles++;
         if (hold_cycles >= 3000) hold_rx <= 1'b0;
      end
   end

   // watchdog: 700 items, long queries, plus stalls, many times over
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2_000_000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0; cycle_count = 0; idle_free = 0; hold_rx = 0;
      hold_cycles = 0; stim_done = 0; drv_busy = 0;
      win_oldest = 0; win_count = 0; win_limit = WinResetValue;
      sym_pool[0] = 64'h0000_0000_4C50_4141;  // short ascii ticker
      sym_pool[1] = 64'h0000_0000_5446_534D;
      sym_pool[2] = 64'hFFFF_FFFF_FFFF_FFFF;
      sym_pool[3] = 64'd0;
      sym_pool[4] = 64'h5A5A_5A5A_5A5A_5A5A;
      sym_pool[5] = 64'h8000_0000_0000_0001;

      // directed: empty query, extremes, zero volume
      push_beat(make_beat(CMD_QUERY, sym_pool[0], 32'd0, 24'd0));
      push_beat(make_beat(CMD_RECORD, sym_pool[2], 32'hFFFF_FFFF, 24'hFF_FFFF));
      push_beat(make_beat(CMD_RECORD, sym_pool[2], 32'hFFFF_FFFF, 24'hFF_FFFF));
      push_beat(make_beat(CMD_RECORD, sym_pool[2], 32'hFFFF_FFFF, 24'hFF_FFFF));
      push_beat(make_beat(CMD_QUERY, sym_pool[2], 32'hFFFF_FFFF, 24'hFF_FFFF));
      push_beat(make_beat(CMD_RECORD, sym_pool[3], 32'd15000, 24'd0));
      push_beat(make_beat(CMD_RECORD, sym_pool[3], 32'd25001, 24'd0));
      push_beat(make_beat(CMD_QUERY, sym_pool[3], 32'd0, 24'd0));
      push_beat(make_beat(CMD_RECORD, sym_pool[4], 32'd10007, 24'd3));
      push_beat(make_beat(CMD_RECORD, sym_pool[4], 32'd20011, 24'd7));
      push_beat(make_beat(CMD_QUERY, sym_pool[4], 32'd0, 24'd0));
      push_beat(make_beat(CMD_QUERY, sym_pool[1], 32'd0, 24'd0));
      // window of one: each trade evicts the last
      push_cfg(9'd1);
      push_beat(make_beat(CMD_RECORD, sym_pool[1], 32'd5, 24'd5));
      push_beat(make_beat(CMD_RECORD, sym_pool[1], 32'd9, 24'd1));
      push_beat(make_beat(CMD_QUERY, sym_pool[1], 32'd0, 24'd0));
      // window size zero acts as one, then oversize clamps
      push_cfg(9'd0);
      push_beat(make_beat(CMD_RECORD, sym_pool[1], 32'd7, 24'd2));
      push_beat(make_beat(CMD_QUERY, sym_pool[1], 32'd0, 24'd0));
      push_cfg(9'd511);
      push_beat(make_beat(CMD_RECORD, sym_pool[1], 32'd3, 24'd4));
      push_beat(make_beat(CMD_QUERY, sym_pool[1], 32'd0, 24'd0));

      // random phases over several window sizes, shrink below count included
      push_cfg(9'd8);   push_random(120);
      push_cfg(9'd256); push_random(300);
      push_cfg(9'd3);   push_random(80);
      push_drain();
      push_cfg(9'd40);  push_random(160);

      @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // long receiver hold-off during the big phase
      wait (pending_ops.size() < 450);
      hold_cycles = 0;
      hold_rx = 1'b1;
      wait (!hold_rx);
      // no-idle stretch
      wait (pending_ops.size() < 250);
      idle_free = 1'b1;
      wait (pending_ops.size() < 150);
      idle_free = 1'b0;

      wait (pending_ops.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

### files.f
+incdir+src
src/wtv_pkg.sv
src/wtv_ram.sv
src/wtv_div.sv
src/windowed_trade_vwap.sv
tb/sv/windowed_trade_vwap_tb.sv
